### rtl/tdf_pkg.sv
// Shared types and constants of the TLV channel deframer.
// Used by tdf_framer and tlv_channel_deframer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tdf_pkg;

	localparam int unsigned IdW    = 9;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned CountW = 9;
	localparam int unsigned RegIdxW = 2;

	localparam logic [IdW-1:0]    PASS_ALL = 9'h1FF;
	localparam logic [CountW-1:0] FULL_LEN = 9'd256;

	localparam logic [RegIdxW-1:0] REG_AUDIO_ID = 2'd0;
	localparam logic [RegIdxW-1:0] REG_META_ID  = 2'd1;

	typedef enum logic [1:0] {
		PH_ID   = 2'd0,
		PH_LEN  = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	typedef struct packed {
		logic             hit;
		logic [ByteW-1:0] data;
		logic             audio;
		logic             meta;
		logic             last;
	} res_t;

endpackage

`default_nettype wire

### rtl/tlv_channel_deframer.sv
// Top level of the TLV channel deframer: configuration registers and result register.
// Depends on tdf_pkg and instantiates tdf_framer.
//
// The input channel (in_valid, in_ready, in_byte) takes one raw stream byte per item.
// Each record is an id byte, a length byte (0 stands for 256) and its payload.
// A payload byte whose record id matches audio_id or meta_id comes out on the
// output channel (out_valid, out_ready) with to_audio, to_meta and record_end.
// Header bytes and bytes of unmatched records give no item. While audio_id
// holds -1 every byte passes through as audio and the framer state is held.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 is audio_id, index 1 is meta_id, other indexes are ignored.
// A result item appears in the cycle after its byte is accepted, and one byte
// is accepted every cycle while in_ready is high; the single result register holds it.
// When the receiver stalls, in_ready stays high only while the result register
// is empty or being drained in the same cycle.
// Reset sets both ids to -1 (passthrough) and the framer to expect an id byte.
`timescale 1ns / 1ps
`default_nettype none

module tlv_channel_deframer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_ready,
	input  wire logic [tdf_pkg::ByteW-1:0]         in_byte,
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic [tdf_pkg::ByteW-1:0]         out_byte,
	output      logic                              to_audio,
	output      logic                              to_meta,
	output      logic                              record_end,
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [tdf_pkg::RegIdxW-1:0]       cfg_index,
	input  wire logic signed [tdf_pkg::IdW-1:0]    cfg_data
);
	import tdf_pkg::*;

	logic signed [IdW-1:0] audio_id_q;
	logic signed [IdW-1:0] meta_id_q;
	logic                  accept;
	logic                  out_valid_q;
	res_t                  res;
	res_t                  res_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_id_q <= PASS_ALL;
			meta_id_q  <= PASS_ALL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_AUDIO_ID: audio_id_q <= cfg_data;
				REG_META_ID:  meta_id_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tdf_framer u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.audio_id (audio_id_q),
		.meta_id  (meta_id_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid && res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = res_q.data;
	assign to_audio   = res_q.audio;
	assign to_meta    = res_q.meta;
	assign record_end = res_q.last;

endmodule

`default_nettype wire

### rtl/tdf_framer.sv
// Record framer: tracks id, length and payload phases and classifies each item.
// Depends on tdf_pkg for the phase type, the result struct and constants.
`timescale 1ns / 1ps
`default_nettype none

module tdf_framer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [tdf_pkg::ByteW-1:0]   in_byte,
	input  wire logic signed [tdf_pkg::IdW-1:0] audio_id,
	input  wire logic signed [tdf_pkg::IdW-1:0] meta_id,
	output tdf_pkg::res_t                    res
);
	import tdf_pkg::*;

	phase_t             phase_q, phase_d;
	logic [ByteW-1:0]   record_id_q, record_id_d;
	logic [CountW-1:0]  bytes_left_q, bytes_left_d;
	logic               pass;
	logic               last;
	logic               is_audio;
	logic               is_meta;

	assign pass     = (audio_id == PASS_ALL);
	assign last     = (bytes_left_q <= 9'd1);
	assign is_audio = (audio_id == {1'b0, record_id_q});
	assign is_meta  = (meta_id == {1'b0, record_id_q});

	always_comb begin
		phase_d      = phase_q;
		record_id_d  = record_id_q;
		bytes_left_d = bytes_left_q;
		if (accept && !pass) begin
			case (phase_q)
				PH_LEN: begin
					phase_d      = PH_DATA;
					bytes_left_d = (in_byte == 8'd0) ? FULL_LEN : {1'b0, in_byte};
				end
				PH_DATA: begin
					if (last) begin
						phase_d      = PH_ID;
						bytes_left_d = '0;
					end else begin
						bytes_left_d = bytes_left_q - 9'd1;
					end
				end
				default: begin
					phase_d     = PH_LEN;
					record_id_d = in_byte;
				end
			endcase
		end
	end

	always_comb begin
		res.data  = in_byte;
		res.hit   = 1'b0;
		res.audio = 1'b0;
		res.meta  = 1'b0;
		res.last  = 1'b0;
		if (pass) begin
			res.hit   = 1'b1;
			res.audio = 1'b1;
		end else begin
			case (phase_q)
				PH_DATA: begin
					res.hit   = is_audio || is_meta;
					res.audio = is_audio;
					res.meta  = is_meta;
					res.last  = last;
				end
				default: begin
					res.hit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_ID;
			record_id_q  <= '0;
			bytes_left_q <= '0;
		end else begin
			phase_q      <= phase_d;
			record_id_q  <= record_id_d;
			bytes_left_q <= bytes_left_d;
		end
	end

endmodule

`default_nettype wire
